FILE: rtl/avad_pkg.sv
// Shared types and constants for the adaptive voice activity detector.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package avad_pkg;

    // Fixed field widths
    localparam int SAMPLE_W = 16;
    localparam int LEVEL_W  = 15;
    localparam int SENS_W   = 10;
    localparam int CFG_W    = 16;
    localparam int BG_W     = 17;   // one background entry, -32768 .. 32768
    localparam int GAIN_W   = 11;   // 640 - sensitivity, signed

    // Threshold arithmetic: history_sum * (640 - sens) / 4096
    localparam int GAIN_BASE = 640;
    localparam int THR_SHIFT = 12;
    localparam int THR_FLOOR = -32768;
    localparam int BG_INIT   = 32768;   // 1.0 in Q1.15

    // Configuration reset values
    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 15'd655;
    localparam logic [SENS_W-1:0]  SENS_RESET  = 10'd128;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_LEVEL_THRESHOLD = 2'd0,
        CFG_SENSITIVITY     = 2'd1
    } t_cfg_index;

    // Per-beat control travelling from front to back
    typedef struct packed {
        logic judge;        // a block closes on this sample and must be judged
        logic buf_end;      // buffer closes on this sample
        logic call_end;     // call closes on this sample
        logic short_buf;    // closing buffer never completed a full block
    } t_mid_flags;

endpackage

FILE: rtl/avad_front.sv
// Front end: accepts samples, keeps the sliding block window and its sum,
// decides where blocks close, and queues classified beats for the back end.
// Depends on avad_pkg.
`timescale 1ns / 1ps

module avad_front #(
    parameter int CHANNELS  = 2,
    parameter int BLOCK_LEN = 128,
    parameter int CH_W      = 1,
    parameter int SUM_W     = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic signed [avad_pkg::SAMPLE_W-1:0] i_sample_value,
    input  logic [CH_W-1:0]                   i_channel_index,
    input  logic                              i_end_of_buffer,
    input  logic                              i_end_of_call,
    output logic                              o_mq_valid,
    input  logic                              i_mq_pop,
    output logic signed [SUM_W-1:0]           o_mq_sum,
    output logic [CH_W-1:0]                   o_mq_ch,
    output avad_pkg::t_mid_flags              o_mq_flags
);
    import avad_pkg::*;

    localparam int PH_W     = $clog2(BLOCK_LEN);
    localparam int MQ_DEPTH = 4;
    localparam int MQ_AW    = $clog2(MQ_DEPTH);
    localparam int MQ_CW    = MQ_AW + 1;
    localparam logic [CH_W:0]   CH_NUM  = (CH_W+1)'(CHANNELS);
    localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);

    // Sample window memory with per-entry valid bits (unwritten reads as zero)
    logic signed [SAMPLE_W-1:0] r_win_mem [BLOCK_LEN];
    logic [BLOCK_LEN-1:0]       r_win_vld;

    logic [PH_W-1:0]            r_phase;
    logic                       r_full_seen;
    logic signed [SUM_W-1:0]    r_wsum;

    // Read stage registers
    logic                       r_s1_valid;
    logic signed [SAMPLE_W-1:0] r_s1_sample;
    logic [CH_W-1:0]            r_s1_ch;
    t_mid_flags                 r_s1_flags;
    logic [PH_W-1:0]            r_s1_addr;
    logic                       r_s1_fwd;
    logic signed [SAMPLE_W-1:0] r_s1_fwd_data;
    logic signed [SAMPLE_W-1:0] r_rd_data;
    logic                       r_rd_vld;

    // Queue towards the back end
    logic signed [SUM_W-1:0]    r_mq_sum   [MQ_DEPTH];
    logic [CH_W-1:0]            r_mq_ch    [MQ_DEPTH];
    t_mid_flags                 r_mq_flags [MQ_DEPTH];
    logic [MQ_AW-1:0]           r_mq_wp;
    logic [MQ_AW-1:0]           r_mq_rp;
    logic [MQ_CW-1:0]           r_mq_cnt;

    logic                       w_accept;
    logic [CH_W-1:0]            w_ch;
    logic                       w_wrap;
    logic [PH_W-1:0]            w_next_phase;
    logic                       w_full_after;
    logic                       w_buf_end;
    t_mid_flags                 w_flags;
    logic signed [SAMPLE_W-1:0] w_old;
    logic signed [SUM_W-1:0]    w_sum_next;
    logic                       w_mq_pop;

    // Credit check: room for the beat in the read stage plus this one
    assign full     = (r_mq_cnt + MQ_CW'(r_s1_valid)) >= MQ_CW'(MQ_DEPTH);
    assign w_accept = push & ~full;

    // Classify the incoming sample
    always_comb begin
        w_ch         = ({1'b0, i_channel_index} >= CH_NUM) ? CH_LAST : i_channel_index;
        w_wrap       = (r_phase == PH_W'(BLOCK_LEN - 1));
        w_next_phase = w_wrap ? '0 : r_phase + PH_W'(1);
        w_full_after = r_full_seen | w_wrap;
        w_buf_end    = i_end_of_buffer | i_end_of_call;
        w_flags.judge     = w_wrap |
                            (w_buf_end & w_full_after & (w_next_phase > PH_W'(BLOCK_LEN / 4)));
        w_flags.buf_end   = w_buf_end;
        w_flags.call_end  = i_end_of_call;
        w_flags.short_buf = ~w_full_after;
    end

    // Block phase tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_full_seen <= 1'b0;
        end else if (w_accept) begin
            r_phase     <= w_buf_end ? '0 : w_next_phase;
            r_full_seen <= w_buf_end ? 1'b0 : w_full_after;
        end
    end

    // Window read at accept; forward when the beat ahead writes the same slot
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd_data     <= r_win_mem[r_phase];
            r_s1_sample   <= i_sample_value;
            r_s1_ch       <= w_ch;
            r_s1_flags    <= w_flags;
            r_s1_addr     <= r_phase;
            r_s1_fwd_data <= r_s1_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_fwd   <= 1'b0;
            r_rd_vld   <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
            if (w_accept) begin
                r_s1_fwd <= r_s1_valid & (r_s1_addr == r_phase);
                r_rd_vld <= r_win_vld[r_phase];
            end
        end
    end

    // Sliding sum update and window write
    always_comb begin
        w_old      = r_s1_fwd ? r_s1_fwd_data : (r_rd_vld ? r_rd_data : '0);
        w_sum_next = r_wsum
                   + {{(SUM_W-SAMPLE_W){r_s1_sample[SAMPLE_W-1]}}, r_s1_sample}
                   - {{(SUM_W-SAMPLE_W){w_old[SAMPLE_W-1]}}, w_old};
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_win_mem[r_s1_addr] <= r_s1_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_vld <= '0;
            r_wsum    <= '0;
        end else if (r_s1_valid) begin
            r_win_vld[r_s1_addr] <= 1'b1;
            r_wsum               <= w_sum_next;
        end
    end

    // Queue to the back end
    assign w_mq_pop   = i_mq_pop & o_mq_valid;
    assign o_mq_valid = (r_mq_cnt != '0);
    assign o_mq_sum   = r_mq_sum[r_mq_rp];
    assign o_mq_ch    = r_mq_ch[r_mq_rp];
    assign o_mq_flags = r_mq_flags[r_mq_rp];

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_mq_sum[r_mq_wp]   <= w_sum_next;
            r_mq_ch[r_mq_wp]    <= r_s1_ch;
            r_mq_flags[r_mq_wp] <= r_s1_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mq_wp  <= '0;
            r_mq_rp  <= '0;
            r_mq_cnt <= '0;
        end else begin
            if (r_s1_valid) begin
                r_mq_wp <= r_mq_wp + MQ_AW'(1);
            end
            if (w_mq_pop) begin
                r_mq_rp <= r_mq_rp + MQ_AW'(1);
            end
            r_mq_cnt <= r_mq_cnt + MQ_CW'(r_s1_valid) - MQ_CW'(w_mq_pop);
        end
    end

endmodule

FILE: rtl/avad_back.sv
// Back end: judges closed blocks against the per-channel threshold, tracks
// the least block, updates the background history and queues call results.
// Depends on avad_pkg.
`timescale 1ns / 1ps

module avad_back #(
    parameter int CHANNELS      = 2,
    parameter int BLOCK_LEN     = 128,
    parameter int HISTORY_DEPTH = 16,
    parameter int CH_W          = 1,
    parameter int SUM_W         = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_mq_valid,
    output logic                            o_mq_pop,
    input  logic signed [SUM_W-1:0]         i_mq_sum,
    input  logic [CH_W-1:0]                 i_mq_ch,
    input  avad_pkg::t_mid_flags            i_mq_flags,
    input  logic [avad_pkg::LEVEL_W-1:0]    i_level,
    input  logic [avad_pkg::SENS_W-1:0]     i_sens,
    output logic                            empty,
    input  logic                            pop,
    output logic                            o_voice_active,
    output logic                            o_short_buffer
);
    import avad_pkg::*;

    localparam int BLK_SH   = $clog2(BLOCK_LEN);
    localparam int SL_W     = $clog2(HISTORY_DEPTH);
    localparam int HM_DEPTH = CHANNELS * HISTORY_DEPTH;
    localparam int HA_W     = $clog2(HM_DEPTH);
    localparam int TOT_W    = BG_W + SL_W;
    localparam int PROD_W   = TOT_W + GAIN_W;
    localparam logic signed [SUM_W-1:0]  LEAST_INIT = SUM_W'(BG_INIT * BLOCK_LEN);
    localparam logic signed [PROD_W-1:0] THR_LOW    = PROD_W'(THR_FLOOR);
    localparam logic signed [GAIN_W-1:0] GAIN_TOP   = GAIN_W'(GAIN_BASE);

    // Background history memory and its valid bits
    logic signed [BG_W-1:0]  r_hist_mem [HM_DEPTH];
    logic [HM_DEPTH-1:0]     r_hist_vld;
    logic signed [TOT_W-1:0] r_total [CHANNELS];
    logic [SL_W-1:0]         r_slot;

    // Buffer and call state
    logic signed [SUM_W-1:0] r_least;
    logic                    r_active;
    logic                    r_short;

    // Work stage registers
    logic                     r_bk_valid;
    logic signed [SUM_W-1:0]  r_bk_sum;
    logic [CH_W-1:0]          r_bk_ch;
    t_mid_flags               r_bk_flags;
    logic [HA_W-1:0]          r_bk_addr;
    logic signed [PROD_W-1:0] r_bk_prod;
    logic signed [TOT_W-1:0]  r_bk_tot;
    logic signed [BG_W-1:0]   r_hist_rd;
    logic                     r_bk_hvld;
    logic                     r_bk_fwd;
    logic signed [BG_W-1:0]   r_bk_fwd_data;

    // Result queue
    logic [1:0] r_oq_act;
    logic [1:0] r_oq_sh;
    logic       r_oq_wp;
    logic       r_oq_rp;
    logic [1:0] r_oq_cnt;

    logic                     w_en;
    logic                     w_done;
    logic                     w_oq_pop;
    logic [HA_W-1:0]          w_haddr;
    logic signed [TOT_W-1:0]  w_tot_raw;
    logic signed [GAIN_W-1:0] w_gain;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] w_thr_full;
    logic signed [PROD_W-1:0] w_thr_min;
    logic signed [PROD_W-1:0] w_level;
    logic signed [SAMPLE_W-1:0] w_thr;
    logic signed [SUM_W-1:0]  w_thr_blk;
    logic                     w_act;
    logic signed [SUM_W-1:0]  w_least_new;
    logic signed [SUM_W-1:0]  w_bg_full;
    logic signed [BG_W-1:0]   w_bg;
    logic signed [BG_W-1:0]   w_hold;
    logic signed [TOT_W-1:0]  w_tot_new;
    logic                     w_active_cur;
    logic                     w_short_cur;

    // Stall only when a call result has nowhere to go
    assign w_en     = ~(r_bk_valid & r_bk_flags.call_end & (r_oq_cnt == 2'd2));
    assign w_done   = r_bk_valid & w_en;
    assign o_mq_pop = i_mq_valid & w_en;

    // Entry: history address, threshold product
    always_comb begin
        w_haddr   = HA_W'(32'(i_mq_ch) * HISTORY_DEPTH + 32'(r_slot));
        w_tot_raw = r_total[i_mq_ch];
        w_gain    = GAIN_TOP - $signed({1'b0, i_sens});
        w_prod    = PROD_W'(w_tot_raw) * PROD_W'(w_gain);
    end

    always_ff @(posedge i_clk) begin
        if (o_mq_pop) begin
            r_bk_sum      <= i_mq_sum;
            r_bk_ch       <= i_mq_ch;
            r_bk_flags    <= i_mq_flags;
            r_bk_addr     <= w_haddr;
            r_bk_prod     <= w_prod;
            r_hist_rd     <= r_hist_mem[w_haddr];
            r_bk_fwd_data <= w_bg;
            // the beat ahead may rewrite this channel's total on this edge
            r_bk_tot      <= (w_done & r_bk_flags.buf_end & (r_bk_ch == i_mq_ch)) ?
                             w_tot_new : w_tot_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bk_valid <= 1'b0;
            r_bk_hvld  <= 1'b0;
            r_bk_fwd   <= 1'b0;
            r_slot     <= '0;
        end else if (w_en) begin
            r_bk_valid <= i_mq_valid;
            if (o_mq_pop) begin
                r_bk_hvld <= r_hist_vld[w_haddr];
                r_bk_fwd  <= r_bk_valid & r_bk_flags.buf_end & (r_bk_addr == w_haddr);
                if (i_mq_flags.call_end) begin
                    r_slot <= (r_slot == SL_W'(HISTORY_DEPTH - 1)) ? '0 : r_slot + SL_W'(1);
                end
            end
        end
    end

    // Judge, least block and background update
    always_comb begin
        w_thr_full   = r_bk_prod >>> THR_SHIFT;
        w_level      = $signed({{(PROD_W-LEVEL_W){1'b0}}, i_level});
        w_thr_min    = (w_thr_full < w_level) ? w_thr_full : w_level;
        w_thr        = (w_thr_min < THR_LOW) ? SAMPLE_W'(THR_LOW) : SAMPLE_W'(w_thr_min);
        w_thr_blk    = {{(SUM_W-SAMPLE_W){w_thr[SAMPLE_W-1]}}, w_thr} <<< BLK_SH;
        w_act        = r_bk_flags.judge & (r_bk_sum > w_thr_blk);
        w_least_new  = (r_bk_flags.judge & (r_bk_sum < r_least)) ? r_bk_sum : r_least;
        w_bg_full    = w_least_new >>> BLK_SH;
        w_bg         = BG_W'(w_bg_full);
        w_hold       = r_bk_fwd ? r_bk_fwd_data : (r_bk_hvld ? r_hist_rd : '0);
        w_tot_new    = r_bk_tot - {{(TOT_W-BG_W){w_hold[BG_W-1]}}, w_hold}
                                + {{(TOT_W-BG_W){w_bg[BG_W-1]}}, w_bg};
        w_active_cur = r_active | w_act;
        w_short_cur  = r_short | (r_bk_flags.buf_end & r_bk_flags.short_buf);
    end

    always_ff @(posedge i_clk) begin
        if (w_done & r_bk_flags.buf_end) begin
            r_hist_mem[r_bk_addr] <= w_bg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_vld <= '0;
            r_least    <= LEAST_INIT;
            r_active   <= 1'b0;
            r_short    <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_total[c] <= '0;
            end
        end else if (w_done) begin
            r_least  <= r_bk_flags.buf_end ? LEAST_INIT : w_least_new;
            r_active <= r_bk_flags.call_end ? 1'b0 : w_active_cur;
            r_short  <= r_bk_flags.call_end ? 1'b0 : w_short_cur;
            if (r_bk_flags.buf_end) begin
                r_hist_vld[r_bk_addr] <= 1'b1;
                r_total[r_bk_ch]      <= w_tot_new;
            end
        end
    end

    // Result queue, two beats deep
    assign empty          = (r_oq_cnt == 2'd0);
    assign w_oq_pop       = pop & ~empty;
    assign o_voice_active = r_oq_act[r_oq_rp];
    assign o_short_buffer = r_oq_sh[r_oq_rp];

    always_ff @(posedge i_clk) begin
        if (w_done & r_bk_flags.call_end) begin
            r_oq_act[r_oq_wp] <= w_active_cur;
            r_oq_sh[r_oq_wp]  <= w_short_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wp  <= 1'b0;
            r_oq_rp  <= 1'b0;
            r_oq_cnt <= 2'd0;
        end else begin
            if (w_done & r_bk_flags.call_end) begin
                r_oq_wp <= ~r_oq_wp;
            end
            if (w_oq_pop) begin
                r_oq_rp <= ~r_oq_rp;
            end
            r_oq_cnt <= r_oq_cnt + 2'(w_done & r_bk_flags.call_end) - 2'(w_oq_pop);
        end
    end

endmodule

FILE: rtl/adaptive_voice_activity_detector_unit.sv
// Top level of the adaptive voice activity detector: configuration
// registers, front end (window and sum) and back end (judge and history).
// Depends on avad_pkg, avad_front, avad_back.
`timescale 1ns / 1ps

// Takes one Q1.15 sample per clock, while full is low, through a push/full
// queue port and gives one result beat (voice_active, short_buffer) per call
// through empty/pop. Sustained rate is one sample per cycle: the sliding
// window memory is read when a sample is taken and written in the next
// cycle, and the back end finishes one beat per cycle unless a call result
// waits on a full result queue. A call's result beat passes the read stage,
// front-to-back queue and back-end work stage; full rises only when the
// four-entry queue between front and back and the two-entry result queue
// back up. No clearing pass after reset. BLOCK_LEN must be a power of two.
// Configuration writes are taken every cycle (cfg ready stays high).
module adaptive_voice_activity_detector_unit #(
    parameter int CHANNELS      = 2,
    parameter int BLOCK_LEN     = 128,
    parameter int HISTORY_DEPTH = 16,
    parameter int CH_W          = 1
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic signed [avad_pkg::SAMPLE_W-1:0] i_sample_value,
    input  logic [CH_W-1:0]                      i_channel_index,
    input  logic                                 i_end_of_buffer,
    input  logic                                 i_end_of_call,
    output logic                                 empty,
    input  logic                                 pop,
    output logic                                 o_voice_active,
    output logic                                 o_short_buffer,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [1:0]                           i_cfg_index,
    input  logic [avad_pkg::CFG_W-1:0]           i_cfg_data
);
    import avad_pkg::*;

    localparam int SUM_W = SAMPLE_W + 1 + $clog2(BLOCK_LEN);

    logic [LEVEL_W-1:0]      r_level;
    logic [SENS_W-1:0]       r_sens;

    logic                    w_mq_valid;
    logic                    w_mq_pop;
    logic signed [SUM_W-1:0] w_mq_sum;
    logic [CH_W-1:0]         w_mq_ch;
    t_mid_flags              w_mq_flags;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= LEVEL_RESET;
            r_sens  <= SENS_RESET;
        end else if (i_cfg_valid & o_cfg_ready) begin
            case (i_cfg_index)
                CFG_LEVEL_THRESHOLD: r_level <= i_cfg_data[LEVEL_W-1:0];
                CFG_SENSITIVITY:     r_sens  <= i_cfg_data[SENS_W-1:0];
                default: ;
            endcase
        end
    end

    avad_front #(
        .CHANNELS  (CHANNELS),
        .BLOCK_LEN (BLOCK_LEN),
        .CH_W      (CH_W),
        .SUM_W     (SUM_W)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_sample_value  (i_sample_value),
        .i_channel_index (i_channel_index),
        .i_end_of_buffer (i_end_of_buffer),
        .i_end_of_call   (i_end_of_call),
        .o_mq_valid      (w_mq_valid),
        .i_mq_pop        (w_mq_pop),
        .o_mq_sum        (w_mq_sum),
        .o_mq_ch         (w_mq_ch),
        .o_mq_flags      (w_mq_flags)
    );

    avad_back #(
        .CHANNELS      (CHANNELS),
        .BLOCK_LEN     (BLOCK_LEN),
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .CH_W          (CH_W),
        .SUM_W         (SUM_W)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_mq_valid     (w_mq_valid),
        .o_mq_pop       (w_mq_pop),
        .i_mq_sum       (w_mq_sum),
        .i_mq_ch        (w_mq_ch),
        .i_mq_flags     (w_mq_flags),
        .i_level        (r_level),
        .i_sens         (r_sens),
        .empty          (empty),
        .pop            (pop),
        .o_voice_active (o_voice_active),
        .o_short_buffer (o_short_buffer)
    );

endmodule
